// ===== design/cmlt_pkg.sv =====
// Shared types and constants for the channel map lookup block.
// Used by cmlt_front, cmlt_back and the top level; no dependencies.
package cmlt_pkg;

   localparam int MAP_DEPTH = 256;
   localparam int UNK_DEPTH = 1024;
   localparam int MAP_AW = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
   localparam int UNK_AW = (UNK_DEPTH > 1) ? $clog2(UNK_DEPTH) : 1;
   localparam int MAP_CW = $clog2(MAP_DEPTH + 1);
   localparam int UNK_CW = $clog2(UNK_DEPTH + 1);
   // wide enough for any index, depth or count at every allowed depth
   localparam int EXT_W = 13;
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      OP_LOAD   = 2'd0,
      OP_LOOKUP = 2'd1,
      OP_READ   = 2'd2,
      OP_NOP    = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAP_RD,
      ST_MAP_CMP,
      ST_UNK_START,
      ST_UNK_RD,
      ST_UNK_CMP,
      ST_APPEND,
      ST_RD_WAIT
   } state_type;

   typedef struct packed {
      op_type     op;
      logic       load_ok;
      logic [7:0] module_req;
      logic [7:0] channel;
      logic [9:0] index;
      logic [3:0] type_in;
      logic [7:0] id_in;
      logic [7:0] det_channel_in;
   } item_type;

   typedef struct packed {
      logic        found;
      logic [3:0]  det_code;
      logic [7:0]  det_id;
      logic [7:0]  det_ch;
      logic [10:0] unknown_total;
      logic        unknown_overflow;
      logic        read_valid;
      logic [7:0]  read_module;
      logic [7:0]  read_channel;
      logic [15:0] read_count;
   } res_type;

   // queue head as seen by the back end
   typedef struct packed {
      logic     valid;
      item_type item;
   } head_type;

endpackage

// ===== design/cmlt_front.sv =====
// Front end: accepts request items, decodes the command and queues them.
// Depends on cmlt_pkg.
module cmlt_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_cmd,
   input  logic [7:0]         req_module_req,
   input  logic [7:0]         req_channel,
   input  logic [9:0]         req_index,
   input  logic [3:0]         req_type_in,
   input  logic [7:0]         req_id_in,
   input  logic [7:0]         req_det_channel_in,
   output cmlt_pkg::head_type head,
   input  logic               pop
);

   localparam int QW = $clog2(cmlt_pkg::QUEUE_DEPTH);

   cmlt_pkg::item_type slot_ff [cmlt_pkg::QUEUE_DEPTH];
   cmlt_pkg::item_type new_item;
   logic [QW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QW:0]   count_ff, count_in;
   logic          push;
   logic          do_pop;

   always_comb begin
      new_item.op             = cmlt_pkg::op_type'(req_cmd);
      new_item.load_ok        = (cmlt_pkg::EXT_W'(req_index) <
                                 cmlt_pkg::EXT_W'(cmlt_pkg::MAP_DEPTH));
      new_item.module_req     = req_module_req;
      new_item.channel        = req_channel;
      new_item.index          = req_index;
      new_item.type_in        = req_type_in;
      new_item.id_in          = req_id_in;
      new_item.det_channel_in = req_det_channel_in;
   end

   assign req_stall = (count_ff == (QW+1)'(cmlt_pkg::QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign do_pop    = pop && (count_ff != '0);

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (QW+1)'(push) - (QW+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= new_item;
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.item  = slot_ff[rd_ptr_ff];

endmodule

// ===== design/cmlt_back.sv =====
// Back end: sequencer over the map memory and the unknown-pair memory,
// plus the result register. Depends on cmlt_pkg.
module cmlt_back (
   input  logic               clock,
   input  logic               reset,
   input  logic [8:0]         active_entries,
   input  cmlt_pkg::head_type head,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output cmlt_pkg::res_type  rsp
);

   localparam int MAW = cmlt_pkg::MAP_AW;
   localparam int UAW = cmlt_pkg::UNK_AW;
   localparam int MCW = cmlt_pkg::MAP_CW;
   localparam int UCW = cmlt_pkg::UNK_CW;
   localparam int XW  = cmlt_pkg::EXT_W;

   logic [35:0] map_mem [cmlt_pkg::MAP_DEPTH];
   logic [31:0] unk_mem [cmlt_pkg::UNK_DEPTH];
   logic [35:0] map_rdata_ff;
   logic [31:0] unk_rdata_ff;

   cmlt_pkg::state_type state_ff, state_in;
   cmlt_pkg::item_type  work_ff, work_in;
   cmlt_pkg::res_type   res_ff, res_in, out_ff, out_in;
   logic [MCW-1:0] map_cnt_ff, map_cnt_in, search_len;
   logic [UCW-1:0] unk_cnt_ff, unk_cnt_in, used_ff, used_in;
   logic           ovf_ff, ovf_in, out_valid_ff, out_valid_in;
   logic           res_pending_ff, res_pending_in;
   logic           done;
   logic           map_we, unk_we;
   logic [MAW-1:0] map_waddr, map_raddr;
   logic [UAW-1:0] unk_waddr, unk_raddr;
   logic [31:0]    unk_wdata;
   logic [XW-1:0]  act_ext, head_idx_ext, used_ext;
   logic [15:0]    pair;
   logic           out_free;

   assign act_ext      = XW'(active_entries);
   assign search_len   = (act_ext > XW'(cmlt_pkg::MAP_DEPTH)) ?
                         MCW'(cmlt_pkg::MAP_DEPTH) : MCW'(act_ext);
   assign head_idx_ext = XW'(head.item.index);
   assign used_ext     = XW'(used_ff);
   assign pair         = {work_ff.module_req, work_ff.channel};
   assign out_free     = !out_valid_ff || !rsp_stall;
   assign map_waddr    = head_idx_ext[MAW-1:0];
   assign map_raddr    = map_cnt_ff[MAW-1:0];

   always_comb begin
      state_in   = state_ff;
      work_in    = work_ff;
      res_in     = res_ff;
      map_cnt_in = map_cnt_ff;
      unk_cnt_in = unk_cnt_ff;
      used_in    = used_ff;
      ovf_in     = ovf_ff;
      pop        = 1'b0;
      done       = 1'b0;
      map_we     = 1'b0;
      unk_we     = 1'b0;
      unk_waddr  = unk_cnt_ff[UAW-1:0];
      unk_wdata  = '0;
      unk_raddr  = unk_cnt_ff[UAW-1:0];
      case (state_ff)
         cmlt_pkg::ST_IDLE: begin
            // A result register that is still full holds the next item back.
            unk_raddr = head_idx_ext[UAW-1:0];
            if (head.valid && !res_pending_ff) begin
               pop        = 1'b1;
               work_in    = head.item;
               res_in     = '0;
               map_cnt_in = '0;
               case (head.item.op)
                  cmlt_pkg::OP_LOAD: begin
                     done = 1'b1;
                  end
                  cmlt_pkg::OP_LOOKUP: begin
                     state_in = (search_len == '0) ? cmlt_pkg::ST_UNK_START :
                                cmlt_pkg::ST_MAP_RD;
                  end
                  cmlt_pkg::OP_READ: begin
                     if (head_idx_ext < used_ext) begin
                        state_in = cmlt_pkg::ST_RD_WAIT;
                     end else begin
                        done = 1'b1;
                     end
                  end
                  default: begin
                     done = 1'b1;
                  end
               endcase
            end
         end
         cmlt_pkg::ST_MAP_RD: begin
            state_in = cmlt_pkg::ST_MAP_CMP;
         end
         cmlt_pkg::ST_MAP_CMP: begin
            if (map_rdata_ff[35:20] == pair) begin
               res_in.found    = 1'b1;
               res_in.det_code = map_rdata_ff[19:16];
               res_in.det_id   = map_rdata_ff[15:8];
               res_in.det_ch   = map_rdata_ff[7:0];
               done            = 1'b1;
               state_in        = cmlt_pkg::ST_IDLE;
            end else begin
               map_cnt_in = map_cnt_ff + 1'b1;
               state_in   = (map_cnt_in == search_len) ? cmlt_pkg::ST_UNK_START :
                            cmlt_pkg::ST_MAP_RD;
            end
         end
         cmlt_pkg::ST_UNK_START: begin
            unk_cnt_in = '0;
            state_in   = (used_ff == '0) ? cmlt_pkg::ST_APPEND : cmlt_pkg::ST_UNK_RD;
         end
         cmlt_pkg::ST_UNK_RD: begin
            state_in = cmlt_pkg::ST_UNK_CMP;
         end
         cmlt_pkg::ST_UNK_CMP: begin
            if (unk_rdata_ff[31:16] == pair) begin
               unk_we    = 1'b1;
               unk_wdata = {pair, (unk_rdata_ff[15:0] == 16'hFFFF) ?
                            unk_rdata_ff[15:0] : unk_rdata_ff[15:0] + 16'd1};
               done      = 1'b1;
               state_in  = cmlt_pkg::ST_IDLE;
            end else begin
               unk_cnt_in = unk_cnt_ff + 1'b1;
               state_in   = (unk_cnt_in == used_ff) ? cmlt_pkg::ST_APPEND :
                            cmlt_pkg::ST_UNK_RD;
            end
         end
         cmlt_pkg::ST_APPEND: begin
            unk_waddr = used_ff[UAW-1:0];
            if (used_ext < XW'(cmlt_pkg::UNK_DEPTH)) begin
               unk_we    = 1'b1;
               unk_wdata = {pair, 16'd1};
               used_in   = used_ff + 1'b1;
            end else begin
               ovf_in = 1'b1;
            end
            done     = 1'b1;
            state_in = cmlt_pkg::ST_IDLE;
         end
         cmlt_pkg::ST_RD_WAIT: begin
            res_in.read_valid   = 1'b1;
            res_in.read_module  = unk_rdata_ff[31:24];
            res_in.read_channel = unk_rdata_ff[23:16];
            res_in.read_count   = unk_rdata_ff[15:0];
            done                = 1'b1;
            state_in            = cmlt_pkg::ST_IDLE;
         end
         default: begin
            state_in = cmlt_pkg::ST_IDLE;
         end
      endcase
      if (pop && head.item.op == cmlt_pkg::OP_LOAD && head.item.load_ok) begin
         map_we = 1'b1;
      end
   end

   // Finished results park in a pending slot until the output register frees.
   always_comb begin
      out_in         = out_ff;
      out_valid_in   = out_valid_ff && rsp_stall;
      res_pending_in = res_pending_ff || done;
      if (res_pending_ff && out_free) begin
         out_in                  = res_ff;
         out_in.unknown_total    = used_ext[10:0];
         out_in.unknown_overflow = ovf_ff;
         out_valid_in            = 1'b1;
         res_pending_in          = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= cmlt_pkg::ST_IDLE;
         used_ff        <= '0;
         ovf_ff         <= 1'b0;
         out_valid_ff   <= 1'b0;
         res_pending_ff <= 1'b0;
      end else begin
         state_ff       <= state_in;
         used_ff        <= used_in;
         ovf_ff         <= ovf_in;
         out_valid_ff   <= out_valid_in;
         res_pending_ff <= res_pending_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff    <= work_in;
      res_ff     <= res_in;
      out_ff     <= out_in;
      map_cnt_ff <= map_cnt_in;
      unk_cnt_ff <= unk_cnt_in;
   end

   always_ff @(posedge clock) begin
      if (map_we) begin
         map_mem[map_waddr] <= {work_in.module_req, work_in.channel, work_in.type_in,
                                work_in.id_in, work_in.det_channel_in};
      end
      map_rdata_ff <= map_mem[map_raddr];
   end

   always_ff @(posedge clock) begin
      if (unk_we) begin
         unk_mem[unk_waddr] <= unk_wdata;
      end
      unk_rdata_ff <= unk_mem[unk_raddr];
   end

   assign rsp_valid = out_valid_ff;
   assign rsp       = out_ff;

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ext <= XW'(cmlt_pkg::UNK_DEPTH))
      else $error("unknown table fill count beyond depth");

   a_ovf_sticky: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |=> ovf_ff)
      else $error("overflow flag cleared outside reset");

   a_used_step: assert property (@(posedge clock) disable iff (reset)
      used_ff != $past(used_ff) |-> used_ff == $past(used_ff) + 1'b1)
      else $error("unknown fill count moved by more than one");

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      pop |-> state_ff == cmlt_pkg::ST_IDLE && !res_pending_ff)
      else $error("item taken while the sequencer was busy");

endmodule

// ===== design/channel_map_lookup_with_miss_tally_top.sv =====
// Top level of the channel map lookup with miss tally.
// Depends on cmlt_pkg, cmlt_front and cmlt_back.
//
// Usage:
//   req_* carries one command item (load map slot, look up a module/channel
//   pair, read an unknown-pair slot); the block raises req_stall while its
//   two-item queue is full. rsp_* returns exactly one result item per
//   request, in order; rsp_stall from the receiver holds the result in the
//   output register while one more item can finish behind it.
//   csr_* writes active_entries (map slots searched by a lookup); write it
//   only while no item is in flight. csr_ready is always high.
// Sequencing, per item in the back-end sequencer (one memory read per
//   entry compared): load, cmd 3 and an out-of-range read finish when
//   taken from the queue; a read in range waits for its unknown-memory read;
//   a lookup scans map slots 0 .. min(active_entries, 256)-1 until a hit,
//   and on a miss scans the u unknown pairs already recorded (scan stops
//   early on a repeat pair), then appends or sets the overflow flag. The
//   result passes through the pending slot and the output register to rsp_*.
// Reset: clears the queue, the sequencer, the unknown fill count, the
//   overflow flag and active_entries. Map and unknown memories are not
//   cleared; unknown slots are used only once written, map slots are not.
module channel_map_lookup_with_miss_tally_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_cmd,
   input  logic [7:0]  req_module_req,
   input  logic [7:0]  req_channel,
   input  logic [9:0]  req_index,
   input  logic [3:0]  req_type_in,
   input  logic [7:0]  req_id_in,
   input  logic [7:0]  req_det_channel_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_found,
   output logic [3:0]  rsp_det_code,
   output logic [7:0]  rsp_det_id,
   output logic [7:0]  rsp_det_ch,
   output logic [10:0] rsp_unknown_total,
   output logic        rsp_unknown_overflow,
   output logic        rsp_read_valid,
   output logic [7:0]  rsp_read_module,
   output logic [7:0]  rsp_read_channel,
   output logic [15:0] rsp_read_count,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [8:0]  csr_data
);

   cmlt_pkg::head_type head;
   cmlt_pkg::res_type  rsp;
   logic               pop;
   logic [8:0]         active_ff;

   // Hold the search length; take a write whenever one arrives.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         active_ff <= csr_data;
      end
   end

   cmlt_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_cmd            (req_cmd),
      .req_module_req     (req_module_req),
      .req_channel        (req_channel),
      .req_index          (req_index),
      .req_type_in        (req_type_in),
      .req_id_in          (req_id_in),
      .req_det_channel_in (req_det_channel_in),
      .head               (head),
      .pop                (pop)
   );

   cmlt_back u_back (
      .clock          (clock),
      .reset          (reset),
      .active_entries (active_ff),
      .head           (head),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp            (rsp)
   );

   assign rsp_found            = rsp.found;
   assign rsp_det_code         = rsp.det_code;
   assign rsp_det_id           = rsp.det_id;
   assign rsp_det_ch           = rsp.det_ch;
   assign rsp_unknown_total    = rsp.unknown_total;
   assign rsp_unknown_overflow = rsp.unknown_overflow;
   assign rsp_read_valid       = rsp.read_valid;
   assign rsp_read_module      = rsp.read_module;
   assign rsp_read_channel     = rsp.read_channel;
   assign rsp_read_count       = rsp.read_count;

endmodule
